// File: hw/rtl/tmic_pkg.sv
// Shared types and constants for the middle-index tensor contraction engine.
// Standalone package; every other file in hw/rtl but tmic_ram imports it.
`default_nettype none

package tmic_pkg;

  // store sizes
  localparam int TENSOR_DEPTH = 4096;
  localparam int MATRIX_DEPTH = 256;
  localparam int TADDR_W      = $clog2(TENSOR_DEPTH);
  localparam int MADDR_W      = $clog2(MATRIX_DEPTH);

  // beat field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 12;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int ACC_W    = 2 * WORD_W;
  localparam int FRAC_W   = 16;

  // configuration register widths
  localparam int DOUT_W = 9;
  localparam int DCON_W = 5;
  localparam int DIN_W  = 9;
  localparam int DRES_W = 5;

  // APB side
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // size check products
  localparam int AB_W  = DOUT_W + DCON_W;
  localparam int AJ_W  = DOUT_W + DRES_W;
  localparam int BC_W  = DCON_W + DIN_W;
  localparam int JB_W  = DRES_W + DCON_W;
  localparam int ABC_W = AB_W + DIN_W;
  localparam int AJC_W = AJ_W + DIN_W;

  // cycles from the last MAC issue until its result word is in the store
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_MATRIX = 2'd0,
    CMD_LOAD_TENSOR = 2'd1,
    CMD_COMPUTE     = 2'd2,
    CMD_READ_RESULT = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_ADDR_RANGE  = 2'd1,
    ST_SIZE_EXCEED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_DIM_OUTER    = 3'd0,
    REG_DIM_CONTRACT = 3'd1,
    REG_DIM_INNER    = 3'd2,
    REG_DIM_RESULT   = 3'd3,
    REG_TRANSPOSE    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_RUN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [DOUT_W-1:0] dim_outer;
    logic [DCON_W-1:0] dim_contract;
    logic [DIN_W-1:0]  dim_inner;
    logic [DRES_W-1:0] dim_result;
    logic              transpose;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic    mat_we;
    logic    ten_we;
    logic    size_load;
    logic    run_init;
    logic    mac_issue;
    logic    mac_first;
    logic    mac_last;
    logic    next_c;
    logic    next_j;
    logic    next_a;
    logic    rsp_push;
    logic    rsp_read;
    status_t rsp_status;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic maddr_ok;
    logic taddr_ok;
    logic size_ok;
    logic pend_full;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/tmic_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on tmic_pkg for field widths.
`default_nettype none

interface tmic_req_if;
  import tmic_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [ADDR_W-1:0]        addr;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, cmd, addr, value, input ready);
  modport sink   (input valid, cmd, addr, value, output ready);
endinterface

interface tmic_rsp_if;
  import tmic_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tmic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/tmic_dp.sv
// Datapath: matrix/tensor/result stores, address walkers, MAC pipeline,
// size check and the two-deep response buffer. Uses tmic_pkg, tmic_ram.
`default_nettype none

module tmic_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tmic_pkg::cfg_t                   cfg,
  input  wire logic [tmic_pkg::ADDR_W-1:0]      req_addr,
  input  wire logic signed [tmic_pkg::WORD_W-1:0] req_value,
  input  wire tmic_pkg::dp_ctl_t                ctl,
  output tmic_pkg::dp_sts_t                     sts,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic signed [tmic_pkg::WORD_W-1:0]    rsp_read_value,
  output logic [tmic_pkg::STATUS_W-1:0]         rsp_status
);
  import tmic_pkg::*;

  function automatic logic [WORD_W-1:0] sat_q16(input logic [ACC_W-1:0] acc);
    logic fits;
    fits = (&acc[ACC_W-1:WORD_W+FRAC_W-1]) || ~(|acc[ACC_W-1:WORD_W+FRAC_W-1]);
    if (fits) begin
      sat_q16 = acc[WORD_W+FRAC_W-1:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      sat_q16 = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_q16 = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  // ---- size check ----
  logic [AB_W-1:0]  ab;
  logic [AJ_W-1:0]  aj;
  logic [BC_W-1:0]  bc;
  logic [JB_W-1:0]  jb;
  logic [ABC_W-1:0] abc;
  logic [AJC_W-1:0] ajc;

  always_ff @(posedge clk) begin
    if (ctl.size_load) begin
      ab <= AB_W'(cfg.dim_outer * cfg.dim_contract);
      aj <= AJ_W'(cfg.dim_outer * cfg.dim_result);
      bc <= BC_W'(cfg.dim_contract * cfg.dim_inner);
      jb <= JB_W'(cfg.dim_result * cfg.dim_contract);
    end
  end

  always_comb begin
    abc = ABC_W'(ab * cfg.dim_inner);
    ajc = AJC_W'(aj * cfg.dim_inner);
  end

  assign sts.size_ok = (32'(abc) <= 32'(TENSOR_DEPTH)) && (32'(ajc) <= 32'(TENSOR_DEPTH))
                    && (32'(jb) <= 32'(MATRIX_DEPTH));
  assign sts.maddr_ok = 32'(req_addr) < 32'(MATRIX_DEPTH);
  assign sts.taddr_ok = 32'(req_addr) < 32'(TENSOR_DEPTH);

  // ---- address walkers ----
  logic [TADDR_W-1:0] u_a, u_c, u_cur;
  logic [MADDR_W-1:0] t_j, t_row, t_cur;
  logic [MADDR_W-1:0] t_step, t_start, t_next_row;
  logic [TADDR_W-1:0] r_cnt;

  always_comb begin
    t_step     = cfg.transpose ? MADDR_W'(cfg.dim_result) : MADDR_W'(1);
    t_start    = cfg.transpose ? t_j : t_row;
    t_next_row = cfg.transpose ? MADDR_W'(t_j + 1'b1)
                               : MADDR_W'(t_row + MADDR_W'(cfg.dim_contract));
  end

  always_ff @(posedge clk) begin
    if (ctl.run_init) begin
      u_a   <= '0;
      u_c   <= '0;
      u_cur <= '0;
      t_j   <= '0;
      t_row <= '0;
      t_cur <= '0;
    end else if (ctl.mac_issue) begin
      if (!ctl.mac_last) begin
        u_cur <= TADDR_W'(u_cur + TADDR_W'(cfg.dim_inner));
        t_cur <= MADDR_W'(t_cur + t_step);
      end else if (ctl.next_c) begin
        u_c   <= TADDR_W'(u_c + 1'b1);
        u_cur <= TADDR_W'(u_c + 1'b1);
        t_cur <= t_start;
      end else if (ctl.next_j) begin
        u_c   <= u_a;
        u_cur <= u_a;
        t_j   <= MADDR_W'(t_j + 1'b1);
        t_row <= MADDR_W'(t_row + MADDR_W'(cfg.dim_contract));
        t_cur <= t_next_row;
      end else if (ctl.next_a) begin
        u_a   <= TADDR_W'(u_a + TADDR_W'(bc));
        u_c   <= TADDR_W'(u_a + TADDR_W'(bc));
        u_cur <= TADDR_W'(u_a + TADDR_W'(bc));
        t_j   <= '0;
        t_row <= '0;
        t_cur <= '0;
      end
    end
  end

  // ---- stores ----
  logic [WORD_W-1:0] mat_rdata, ten_rdata, res_rdata, res_wdata;
  logic              res_we;

  tmic_ram #(.WIDTH(WORD_W), .DEPTH(MATRIX_DEPTH)) u_mat (
    .clk   (clk),
    .we    (ctl.mat_we),
    .waddr (MADDR_W'(req_addr)),
    .wdata (req_value),
    .raddr (t_cur),
    .rdata (mat_rdata)
  );

  tmic_ram #(.WIDTH(WORD_W), .DEPTH(TENSOR_DEPTH)) u_ten (
    .clk   (clk),
    .we    (ctl.ten_we),
    .waddr (TADDR_W'(req_addr)),
    .wdata (req_value),
    .raddr (u_cur),
    .rdata (ten_rdata)
  );

  tmic_ram #(.WIDTH(WORD_W), .DEPTH(TENSOR_DEPTH)) u_res (
    .clk   (clk),
    .we    (res_we),
    .waddr (r_cnt),
    .wdata (res_wdata),
    .raddr (TADDR_W'(req_addr)),
    .rdata (res_rdata)
  );

  // ---- MAC pipeline: store read, multiply, accumulate ----
  logic                    s1_valid, s1_first, s1_last;
  logic                    s2_valid, s2_first, s2_last;
  logic                    s3_valid, s3_last;
  logic signed [ACC_W-1:0] prod;
  logic [ACC_W-1:0]        acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.mac_issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= ctl.mac_first;
    s1_last  <= ctl.mac_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s3_last  <= s2_last;
    // no contracted terms: every sum is zero
    if (cfg.dim_contract == '0) begin
      prod <= '0;
    end else begin
      prod <= $signed(mat_rdata) * $signed(ten_rdata);
    end
    if (s2_valid) begin
      acc <= s2_first ? prod : ACC_W'(acc + prod);
    end
  end

  assign res_we    = s3_valid && s3_last;
  assign res_wdata = sat_q16(acc);

  always_ff @(posedge clk) begin
    if (ctl.run_init) begin
      r_cnt <= '0;
    end else if (res_we) begin
      r_cnt <= TADDR_W'(r_cnt + 1'b1);
    end
  end

  // ---- response buffer: output register plus one skid entry ----
  logic                pend_valid;
  logic [WORD_W-1:0]   pend_value;
  logic [STATUS_W-1:0] pend_status;
  logic [WORD_W-1:0]   push_value;
  logic                out_free;

  assign push_value = ctl.rsp_read ? res_rdata : '0;
  assign out_free   = !rsp_valid || rsp_ready;
  assign sts.pend_full = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        rsp_valid  <= 1'b1;
        pend_valid <= ctl.rsp_push;
      end else begin
        rsp_valid  <= ctl.rsp_push;
      end
    end else if (ctl.rsp_push) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        rsp_read_value <= pend_value;
        rsp_status     <= pend_status;
        pend_value     <= push_value;
        pend_status    <= ctl.rsp_status;
      end else begin
        rsp_read_value <= push_value;
        rsp_status     <= ctl.rsp_status;
      end
    end else if (ctl.rsp_push) begin
      pend_value  <= push_value;
      pend_status <= ctl.rsp_status;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tmic_ctrl.sv
// Controller: command decode, size-check sequencing and the a/j/c/b loop
// counters that drive the MAC pipeline. Uses tmic_pkg.
`default_nettype none

module tmic_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tmic_pkg::cfg_t    cfg,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire tmic_pkg::cmd_t    req_cmd,
  output tmic_pkg::dp_ctl_t      ctl,
  input  wire tmic_pkg::dp_sts_t sts
);
  import tmic_pkg::*;

  state_t state, state_next;

  logic [DOUT_W-1:0]  a_cnt;
  logic [DRES_W-1:0]  j_cnt;
  logic [DIN_W-1:0]   c_cnt;
  logic [DCON_W-1:0]  b_cnt;
  logic [DRAIN_W-1:0] drain_cnt;
  logic               a_last, j_last, c_last, b_last;
  logic               any_zero, accept;

  always_comb begin
    a_last   = DOUT_W'(a_cnt + 1'b1) == cfg.dim_outer;
    j_last   = DRES_W'(j_cnt + 1'b1) == cfg.dim_result;
    c_last   = DIN_W'(c_cnt + 1'b1) == cfg.dim_inner;
    // zero contract size: one issue per result word, which comes out zero
    b_last   = (DCON_W'(b_cnt + 1'b1) == cfg.dim_contract) || (cfg.dim_contract == '0);
    any_zero = (cfg.dim_outer == '0) || (cfg.dim_result == '0)
            || (cfg.dim_inner == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = (state == S_IDLE) && !sts.pend_full;
    accept     = req_valid && req_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_cmd)
            CMD_LOAD_MATRIX: begin
              ctl.mat_we     = sts.maddr_ok;
              ctl.rsp_push   = 1'b1;
              ctl.rsp_status = sts.maddr_ok ? ST_OK : ST_ADDR_RANGE;
            end
            CMD_LOAD_TENSOR: begin
              ctl.ten_we     = sts.taddr_ok;
              ctl.rsp_push   = 1'b1;
              ctl.rsp_status = sts.taddr_ok ? ST_OK : ST_ADDR_RANGE;
            end
            CMD_COMPUTE: begin
              ctl.size_load = 1'b1;
              state_next    = S_CHECK;
            end
            CMD_READ_RESULT: begin
              if (sts.taddr_ok) begin
                state_next = S_READ;
              end else begin
                ctl.rsp_push   = 1'b1;
                ctl.rsp_status = ST_ADDR_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        ctl.rsp_push   = 1'b1;
        ctl.rsp_read   = 1'b1;
        ctl.rsp_status = ST_OK;
        state_next     = S_IDLE;
      end
      S_CHECK: begin
        if (!sts.size_ok) begin
          ctl.rsp_push   = 1'b1;
          ctl.rsp_status = ST_SIZE_EXCEED;
          state_next     = S_IDLE;
        end else if (any_zero) begin
          ctl.rsp_push   = 1'b1;
          ctl.rsp_status = ST_OK;
          state_next     = S_IDLE;
        end else begin
          ctl.run_init = 1'b1;
          state_next   = S_RUN;
        end
      end
      S_RUN: begin
        ctl.mac_issue = 1'b1;
        ctl.mac_first = b_cnt == '0;
        ctl.mac_last  = b_last;
        ctl.next_c    = b_last && !c_last;
        ctl.next_j    = b_last && c_last && !j_last;
        ctl.next_a    = b_last && c_last && j_last && !a_last;
        if (b_last && c_last && j_last && a_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_cnt == DRAIN_W'(DRAIN_CYCLES - 1)) begin
          ctl.rsp_push   = 1'b1;
          ctl.rsp_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // loop counters, b innermost
  always_ff @(posedge clk) begin
    if (rst || state == S_CHECK) begin
      a_cnt <= '0;
      j_cnt <= '0;
      c_cnt <= '0;
      b_cnt <= '0;
    end else if (state == S_RUN) begin
      b_cnt <= b_last ? '0 : DCON_W'(b_cnt + 1'b1);
      if (b_last) begin
        c_cnt <= c_last ? '0 : DIN_W'(c_cnt + 1'b1);
        if (c_last) begin
          j_cnt <= j_last ? '0 : DRES_W'(j_cnt + 1'b1);
          if (j_last) begin
            a_cnt <= DOUT_W'(a_cnt + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state != S_DRAIN) begin
      drain_cnt <= '0;
    end else begin
      drain_cnt <= DRAIN_W'(drain_cnt + 1'b1);
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.rsp_push |-> !sts.pend_full)
    else $error("response pushed into a full buffer");

  a_compute_check: assert property (@(posedge clk) disable iff (rst)
    accept && req_cmd == CMD_COMPUTE |=> state == S_CHECK)
    else $error("compute did not enter size check");

  a_b_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> (b_cnt == '0) || (b_cnt < cfg.dim_contract))
    else $error("contract counter past its size");

  a_no_rsp_in_run: assert property (@(posedge clk) disable iff (rst)
    ctl.mac_issue |-> !ctl.rsp_push)
    else $error("response issued during MAC run");

endmodule

`default_nettype wire

// File: hw/rtl/tensor_middle_index_contract.sv
// Top level of the middle-index tensor contraction engine: APB register
// file, controller and datapath. Uses tmic_pkg, tmic_if, tmic_ctrl, tmic_dp.
//
//   channel | kind        | beat / access
//   --------+-------------+---------------------------------------------
//   req     | valid/ready | cmd, addr, value (load, compute, read cmd)
//   rsp     | valid/ready | read_value, status (one beat per req beat)
//   apb     | APB write   | dim regs at paddr 4*i, pready tied high
//
// Loads answer straight from idle; a result read passes through S_READ for the
// registered store read. Compute runs one MAC pipeline, one product a cycle,
// each store read through its single read port; with B zero every result word
// is written as zero. A size error or a zero A, J or C answers from S_CHECK.
// Reset (rst, sync) sets dims to 1 and transpose to 0; stores are not cleared.
// A stalled rsp holds one beat in the output register and one in a skid entry;
// req is taken again as soon as the skid entry is empty.
`default_nettype none

module tensor_middle_index_contract (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tmic_req_if.sink                           req,
  tmic_rsp_if.source                         rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tmic_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tmic_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tmic_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import tmic_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_we;
  dp_ctl_t  ctl;
  dp_sts_t  sts;

  // ---- register file ----
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_outer    <= DOUT_W'(1);
      cfg.dim_contract <= DCON_W'(1);
      cfg.dim_inner    <= DIN_W'(1);
      cfg.dim_result   <= DRES_W'(1);
      cfg.transpose    <= 1'b0;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_DIM_OUTER:    cfg.dim_outer    <= pwdata[DOUT_W-1:0];
        REG_DIM_CONTRACT: cfg.dim_contract <= pwdata[DCON_W-1:0];
        REG_DIM_INNER:    cfg.dim_inner    <= pwdata[DIN_W-1:0];
        REG_DIM_RESULT:   cfg.dim_result   <= pwdata[DRES_W-1:0];
        REG_TRANSPOSE:    cfg.transpose    <= pwdata[0];
        default: ;  // holes in the map ignore writes
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DIM_OUTER:    prdata = PDATA_W'(cfg.dim_outer);
      REG_DIM_CONTRACT: prdata = PDATA_W'(cfg.dim_contract);
      REG_DIM_INNER:    prdata = PDATA_W'(cfg.dim_inner);
      REG_DIM_RESULT:   prdata = PDATA_W'(cfg.dim_result);
      REG_TRANSPOSE:    prdata = PDATA_W'(cfg.transpose);
      default:          prdata = '0;
    endcase
  end

  // ---- controller: decode and loop sequencing ----
  tmic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (cmd_t'(req.cmd)),
    .ctl       (ctl),
    .sts       (sts)
  );

  // ---- datapath: stores, MAC pipeline, response buffer ----
  tmic_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .req_addr       (req.addr),
    .req_value      (req.value),
    .ctl            (ctl),
    .sts            (sts),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the middle-index tensor contraction engine.
// Needs tmic_pkg, tmic_req_if/tmic_rsp_if and tensor_middle_index_contract.
`timescale 1ns / 1ps

module testbench;
  import tmic_pkg::*;

  localparam int          ITEM_TARGET  = 1275;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'shFFFF_FFFF_8000_0000;

  // one expected response beat
  typedef struct {
    logic [WORD_W-1:0] word;
    status_t           code;
  } reply_t;

  // Mirrors the engine: stores, dims and the queue of replies still owed.
  class contraction_board;
    logic [WORD_W-1:0] mat [MATRIX_DEPTH];
    logic [WORD_W-1:0] ten [TENSOR_DEPTH];
    logic [WORD_W-1:0] res [TENSOR_DEPTH];
    int unsigned d_outer = 1, d_contract = 1, d_inner = 1, d_result = 1;
    bit          transpose = 0;
    reply_t      expected_replies [$];
    int          errors = 0;

    function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] v);
      case (idx)
        REG_DIM_OUTER:    d_outer    = v[DOUT_W-1:0];
        REG_DIM_CONTRACT: d_contract = v[DCON_W-1:0];
        REG_DIM_INNER:    d_inner    = v[DIN_W-1:0];
        REG_DIM_RESULT:   d_result   = v[DRES_W-1:0];
        REG_TRANSPOSE:    transpose  = v[0];
        default: ;
      endcase
    endfunction

    // V[a][j][c] = sum_b T(j,b) * U[a][b][c], Q32.32 sum >>> 16, saturated
    function status_t contract_stores();
      int unsigned       ti, ui;
      logic signed [63:0] acc, lhs, rhs, shifted;
      if (d_outer * d_contract * d_inner > TENSOR_DEPTH ||
          d_outer * d_result * d_inner > TENSOR_DEPTH ||
          d_result * d_contract > MATRIX_DEPTH)
        return ST_SIZE_EXCEED;
      for (int a = 0; a < d_outer; a++)
        for (int j = 0; j < d_result; j++)
          for (int c = 0; c < d_inner; c++) begin
            acc = '0;
            for (int b = 0; b < d_contract; b++) begin
              ti  = transpose ? b * d_result + j : j * d_contract + b;
              ui  = (a * d_contract + b) * d_inner + c;
              lhs = $signed(mat[ti]);
              rhs = $signed(ten[ui]);
              acc = acc + lhs * rhs;  // wraps mod 2^64 like the hardware
            end
            shifted = acc >>> FRAC_W;
            if (shifted > Q_MAX)
              res[(a * d_result + j) * d_inner + c] = Q_MAX[WORD_W-1:0];
            else if (shifted < Q_MIN)
              res[(a * d_result + j) * d_inner + c] = Q_MIN[WORD_W-1:0];
            else
              res[(a * d_result + j) * d_inner + c] = shifted[WORD_W-1:0];
          end
      return ST_OK;
    endfunction

    function void take_request(cmd_t c, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] v);
      reply_t r;
      r.word = '0;
      r.code = ST_OK;
      case (c)
        CMD_LOAD_MATRIX: begin
          if (a < MATRIX_DEPTH) mat[a] = v;
          else r.code = ST_ADDR_RANGE;
        end
        CMD_LOAD_TENSOR: ten[a] = v;  // 12-bit addr always inside the store
        CMD_COMPUTE:     r.code = contract_stores();
        default:         r.word = res[a];
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [WORD_W-1:0] rv, logic [STATUS_W-1:0] st);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("unexpected beat: read_value %h status %0d", rv, st);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (rv !== want.word) begin
        $error("read_value: expected %h, actual %h", want.word, rv);
        errors++;
      end
      if (st !== want.code) begin
        $error("status: expected %0d, actual %0d", want.code, st);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  tmic_req_if req_ch();
  tmic_rsp_if rsp_ch();

  tensor_middle_index_contract u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  contraction_board board = new();

  // Stimulus-side view: which store words hold data, so that no compute or
  // read ever touches a word that was never written.
  bit          mat_ok [MATRIX_DEPTH];
  bit          ten_ok [TENSOR_DEPTH];
  int unsigned res_hi = 0;  // results [0, res_hi) have been produced
  int unsigned g_outer = 1, g_contract = 1, g_inner = 1, g_result = 1;
  int          beats_sent = 0;
  bit          quiet_send = 0, quiet_recv = 0;  // no idling on that side
  int          hold_cycles = 0;                 // long rsp hold-off request
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL tensor_middle_index_contract");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd   = '0;
    req_ch.addr  = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
  end

  function automatic bit gen_fits();
    return g_outer * g_contract * g_inner <= TENSOR_DEPTH &&
           g_outer * g_result * g_inner <= TENSOR_DEPTH &&
           g_result * g_contract <= MATRIX_DEPTH;
  endfunction

  function automatic bit inputs_written();
    for (int i = 0; i < g_result * g_contract; i++)
      if (!mat_ok[i]) return 0;
    for (int i = 0; i < g_outer * g_contract * g_inner; i++)
      if (!ten_ok[i]) return 0;
    return 1;
  endfunction

  // Q16.16 operand: saturation corners, full random, or a few units
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom;
      default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    endcase
  endfunction

  // One request beat: random gap, then hold valid until ready.
  task automatic send_beat(cmd_t c, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] v);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.cmd   = c;
    req_ch.addr  = a;
    req_ch.value = v;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    board.take_request(c, a, v);
    beats_sent++;
    case (c)
      CMD_LOAD_MATRIX: if (a < MATRIX_DEPTH) mat_ok[a] = 1'b1;
      CMD_LOAD_TENSOR: ten_ok[a] = 1'b1;
      CMD_COMPUTE: begin
        if (gen_fits() && g_outer * g_result * g_inner > res_hi)
          res_hi = g_outer * g_result * g_inner;
      end
      default: ;
    endcase
  endtask

  task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_dims(int unsigned a, int unsigned b, int unsigned c, int unsigned j,
                          bit t);
    apb_write(REG_DIM_OUTER, a);
    apb_write(REG_DIM_CONTRACT, b);
    apb_write(REG_DIM_INNER, c);
    apb_write(REG_DIM_RESULT, j);
    apb_write(REG_TRANSPOSE, t);
    g_outer    = a;
    g_contract = b;
    g_inner    = c;
    g_result   = j;
  endtask

  // sender stops and waits for every owed beat, plus the MAC drain
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 8) @(posedge clk);
  endtask

  // load every word the next compute reads, re-loading some at random
  task automatic fill_inputs();
    int nm, nt;
    nm = g_result * g_contract;
    nt = g_outer * g_contract * g_inner;
    for (int i = 0; i < nm; i++)
      if (!mat_ok[i] || (nm <= 64 && $urandom_range(0, 3) == 0))
        send_beat(CMD_LOAD_MATRIX, 12'(i), pick_word());
    for (int i = 0; i < nt; i++)
      if (!ten_ok[i] || (nt <= 64 && $urandom_range(0, 3) == 0))
        send_beat(CMD_LOAD_TENSOR, 12'(i), pick_word());
  endtask

  // Response side: random stall per beat, plus a long hold-off on request.
  initial begin
    int stall, held;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        held        = hold_cycles;
        hold_cycles = 0;
        rsp_ch.ready = 1'b0;
        repeat (held) @(negedge clk);
      end
      stall = quiet_recv ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      board.check_reply(rsp_ch.read_value, rsp_ch.status);
    end
  end

  initial begin
    int          phase, nsel, nread, nnoise, work;
    int unsigned a, b, c, j, span;
    bit          t;
    phase = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part, reset dims (all sizes 1, no transpose) ---
    // positive overflow of one product saturates high
    send_beat(CMD_LOAD_MATRIX, 12'd0, 32'h8000_0000);
    send_beat(CMD_LOAD_TENSOR, 12'd0, 32'h8000_0000);
    send_beat(CMD_COMPUTE, 12'hFFF, $urandom);
    send_beat(CMD_READ_RESULT, 12'd0, 32'hFFFF_FFFF);
    // negative product saturates low
    send_beat(CMD_LOAD_MATRIX, 12'd0, 32'h7FFF_FFFF);
    send_beat(CMD_COMPUTE, 12'd0, 32'h0);
    send_beat(CMD_READ_RESULT, 12'd0, 32'h0);
    // shift rounds toward minus infinity: 1 lsb * -1 lsb gives -1 lsb
    send_beat(CMD_LOAD_MATRIX, 12'd0, 32'h0000_0001);
    send_beat(CMD_LOAD_TENSOR, 12'd0, 32'hFFFF_FFFF);
    send_beat(CMD_COMPUTE, 12'h555, 32'h5555_5555);
    send_beat(CMD_READ_RESULT, 12'd0, 32'hAAAA_AAAA);
    // matrix loads past the store report an address error; the top words load ok
    send_beat(CMD_LOAD_MATRIX, 12'd256, 32'h1234_5678);
    send_beat(CMD_LOAD_MATRIX, 12'hFFF, 32'h7FFF_FFFF);
    send_beat(CMD_LOAD_MATRIX, 12'd255, 32'hAAAA_AAAA);
    send_beat(CMD_LOAD_TENSOR, 12'hFFF, 32'h5555_5555);

    // two products of 2^62 wrap the 64-bit sum to negative -> low saturation
    settle();
    set_dims(1, 2, 1, 1, 0);
    send_beat(CMD_LOAD_MATRIX, 12'd0, 32'h8000_0000);
    send_beat(CMD_LOAD_MATRIX, 12'd1, 32'h8000_0000);
    send_beat(CMD_LOAD_TENSOR, 12'd0, 32'h8000_0000);
    send_beat(CMD_LOAD_TENSOR, 12'd1, 32'h8000_0000);
    send_beat(CMD_COMPUTE, 12'd0, 32'h0);
    send_beat(CMD_READ_RESULT, 12'd0, 32'h0);

    // zero size: compute is a no-op with ok status
    settle();
    set_dims(0, 2, 1, 1, 0);
    send_beat(CMD_COMPUTE, 12'd0, 32'h0);
    // outer size beyond the tensor store
    settle();
    set_dims(511, 31, 511, 31, 1);
    send_beat(CMD_COMPUTE, 12'd0, 32'h0);
    // matrix product J*B beyond the matrix store
    settle();
    set_dims(1, 16, 1, 17, 0);
    send_beat(CMD_COMPUTE, 12'd0, 32'h0);

    // --- random phases: new dims, load, compute, read back, then noise ---
    while (beats_sent < ITEM_TARGET) begin
      phase++;
      settle();
      t = $urandom_range(0, 1);
      case ($urandom_range(0, 11))
        0: begin
          nsel = $urandom_range(0, 4);
          case (nsel)
            0: begin a = 256; b = 1;  c = 1;   j = 16; end
            1: begin a = 1;   b = 1;  c = 256; j = 16; end
            2: begin a = 1;   b = 16; c = 1;   j = 16; end
            3: begin  // some size zero
              a = $urandom_range(0, 3); b = $urandom_range(0, 3);
              c = $urandom_range(0, 3); j = $urandom_range(0, 3);
              case ($urandom_range(0, 3))
                0: a = 0;
                1: b = 0;
                2: c = 0;
                default: j = 0;
              endcase
            end
            default: begin
              if ($urandom_range(0, 1)) begin
                a = $urandom_range(257, 511); b = $urandom_range(1, 31);
                c = $urandom_range(17, 511);  j = $urandom_range(1, 31);
              end else begin
                a = 1; c = 1;
                b = $urandom_range(17, 31); j = $urandom_range(16, 31);
              end
            end
          endcase
        end
        1, 2: begin
          a = $urandom_range(1, 6); b = $urandom_range(1, 4);
          c = $urandom_range(1, 6); j = $urandom_range(1, 4);
        end
        default: begin
          a = $urandom_range(1, 3); b = $urandom_range(1, 3);
          c = $urandom_range(1, 3); j = $urandom_range(1, 3);
        end
      endcase
      set_dims(a, b, c, j, t);

      quiet_send = ($urandom_range(0, 3) == 0);
      quiet_recv = ($urandom_range(0, 3) == 0);
      // back-pressure phase: rsp held off long while beats keep coming
      if (phase == 3 || phase == 17) begin
        quiet_send  = 1'b1;
        hold_cycles = 400;
      end

      if (gen_fits()) fill_inputs();
      send_beat(CMD_COMPUTE, 12'($urandom), $urandom);

      span = g_outer * g_result * g_inner;
      if (gen_fits() && span > 0) begin
        nread = $urandom_range(1, 6);
        for (int k = 0; k < nread; k++)
          send_beat(CMD_READ_RESULT,
                    12'(k == 0 ? span - 1 : $urandom_range(0, span - 1)), $urandom);
      end

      nnoise = $urandom_range(0, 10);
      for (int k = 0; k < nnoise; k++) begin
        case ($urandom_range(0, 3))
          0: send_beat(CMD_LOAD_MATRIX,
                       12'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 4095)),
                       pick_word());
          1: send_beat(CMD_LOAD_TENSOR, 12'($urandom_range(0, 4095)), pick_word());
          2: if (res_hi > 0)
               send_beat(CMD_READ_RESULT, 12'($urandom_range(0, res_hi - 1)), $urandom);
          default: begin
            work = g_outer * g_result * g_inner * g_contract;
            if (!gen_fits() || (inputs_written() && work <= 5000))
              send_beat(CMD_COMPUTE, 12'($urandom), $urandom);
          end
        endcase
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0)
      $display("PASS tensor_middle_index_contract");
    else
      $display("FAIL tensor_middle_index_contract");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tmic_pkg.sv
hw/rtl/tmic_if.sv
hw/rtl/tmic_ram.sv
hw/rtl/tmic_dp.sv
hw/rtl/tmic_ctrl.sv
hw/rtl/tensor_middle_index_contract.sv
test/testbench.sv
